@@ hw/rtl/u8dec_pkg.sv @@
// shared types and constants for the utf-8 stream decoder
package u8dec_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] MaxBytesReset = 8'd128;

  // lead byte classes
  localparam logic [3:0] HiThreeByte = 4'he;
  localparam logic [3:0] HiTwoByteA  = 4'hc;
  localparam logic [3:0] HiTwoByteB  = 4'hd;

  // continuation bytes still expected
  localparam logic [1:0] NeedNone = 2'd0;
  localparam logic [1:0] NeedOne  = 2'd1;
  localparam logic [1:0] NeedTwo  = 2'd2;

  // one queue entry: an optional character request and an optional terminator
  typedef struct packed {
    logic        char_valid;
    logic [15:0] code_point;
    logic [7:0]  char_index;
    logic        is_unknown;
    logic        term_valid;
    logic [7:0]  char_count;
  } u8dec_entry_t;

  // queue handshake between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } u8dec_fifo_status_t;

endpackage

@@ hw/rtl/u8dec_front.sv @@
// front end: per-byte utf-8 decode state and request classification
module u8dec_front import u8dec_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output logic         entry_push,
  output u8dec_entry_t entry
);

  logic [7:0] max_input_bytes;
  logic [7:0] lead_bits, lead_bits_next;
  logic [7:0] first_continuation, first_continuation_next;
  logic [1:0] bytes_still_needed, bytes_still_needed_next;
  logic [7:0] chars_emitted, chars_emitted_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic       decode_stopped, decode_stopped_next;

  logic        in_window;
  logic        char_v;
  logic        unk;
  logic [15:0] cp;
  logic [7:0]  chars_after;

  always_comb begin
    lead_bits_next          = lead_bits;
    first_continuation_next = first_continuation;
    bytes_still_needed_next = bytes_still_needed;
    bytes_seen_next         = bytes_seen;
    decode_stopped_next     = decode_stopped;
    char_v                  = 1'b0;
    unk                     = 1'b0;
    cp                      = 16'd0;
    in_window               = !decode_stopped && (bytes_seen < max_input_bytes);

    if (in_window) begin
      bytes_seen_next = bytes_seen + 8'd1;
      case (bytes_still_needed)
        NeedNone: begin
          if (!data_byte[7]) begin
            char_v = 1'b1;
            cp     = {8'd0, data_byte};
          end else if (data_byte[7:4] == HiThreeByte) begin
            lead_bits_next          = data_byte;
            bytes_still_needed_next = NeedTwo;
          end else if (data_byte[7:4] == HiTwoByteA || data_byte[7:4] == HiTwoByteB) begin
            lead_bits_next          = data_byte;
            bytes_still_needed_next = NeedOne;
          end else begin
            char_v = 1'b1;
            unk    = 1'b1;
          end
        end
        NeedTwo: begin
          first_continuation_next = data_byte;
          bytes_still_needed_next = NeedOne;
        end
        default: begin
          // final continuation byte; an out-of-range need count lands here too
          if (lead_bits[7:4] == HiThreeByte) begin
            cp = {lead_bits[3:0], first_continuation[5:0], data_byte[5:0]};
          end else begin
            cp = {5'd0, lead_bits[4:0], data_byte[5:0]};
          end
          char_v                  = 1'b1;
          bytes_still_needed_next = NeedNone;
        end
      endcase
      // sequence left open at the cap never completes
      if (bytes_still_needed_next != NeedNone && bytes_seen_next >= max_input_bytes) begin
        decode_stopped_next     = 1'b1;
        bytes_still_needed_next = NeedNone;
      end
    end

    chars_after        = char_v ? chars_emitted + 8'd1 : chars_emitted;
    chars_emitted_next = chars_after;

    if (last_byte) begin
      lead_bits_next          = 8'd0;
      first_continuation_next = 8'd0;
      bytes_still_needed_next = NeedNone;
      chars_emitted_next      = 8'd0;
      bytes_seen_next         = 8'd0;
      decode_stopped_next     = 1'b0;
    end
  end

  assign entry.char_valid = char_v;
  assign entry.code_point = cp;
  assign entry.char_index = chars_emitted;
  assign entry.is_unknown = unk;
  assign entry.term_valid = last_byte;
  assign entry.char_count = chars_after;
  assign entry_push       = accept && (char_v || last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_input_bytes <= MaxBytesReset;
    end else if (cfg_wr_en) begin
      max_input_bytes <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_bits          <= 8'd0;
      first_continuation <= 8'd0;
      bytes_still_needed <= NeedNone;
      chars_emitted      <= 8'd0;
      bytes_seen         <= 8'd0;
      decode_stopped     <= 1'b0;
    end else if (accept) begin
      lead_bits          <= lead_bits_next;
      first_continuation <= first_continuation_next;
      bytes_still_needed <= bytes_still_needed_next;
      chars_emitted      <= chars_emitted_next;
      bytes_seen         <= bytes_seen_next;
      decode_stopped     <= decode_stopped_next;
    end
  end

endmodule

@@ hw/rtl/u8dec_fifo.sv @@
// small request queue between front and back
module u8dec_fifo import u8dec_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  u8dec_entry_t       wr_data,
  input  logic               rd_en,
  output u8dec_entry_t       rd_data,
  output u8dec_fifo_status_t status
);

  u8dec_entry_t        mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [FifoCntW-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign status.full  = (count == FifoCntW'(FifoDepth));
  assign status.empty = (count == '0);
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;
  assign rd_data      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + FifoPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + FifoPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + FifoCntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - FifoCntW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/u8dec_back.sv @@
// back end: expands queue entries into character and terminator results
module u8dec_back import u8dec_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  u8dec_fifo_status_t fifo_status,
  input  u8dec_entry_t       fifo_data,
  output logic               fifo_rd,
  input  logic               pop,
  output logic               empty,
  output logic [15:0]        code_point,
  output logic [7:0]         char_index,
  output logic               is_unknown,
  output logic               is_terminator,
  output logic [7:0]         char_count
);

  u8dec_entry_t cur;
  logic         char_pend;
  logic         term_pend;
  logic         take;
  logic         finishing;

  assign empty     = !(char_pend || term_pend);
  assign take      = pop && !empty;
  assign finishing = take && !(char_pend && term_pend);
  assign fifo_rd   = !fifo_status.empty && (empty || finishing);

  assign code_point    = char_pend ? cur.code_point : 16'd0;
  assign char_index    = char_pend ? cur.char_index : 8'd0;
  assign is_unknown    = char_pend ? cur.is_unknown : 1'b0;
  assign is_terminator = !char_pend;
  assign char_count    = char_pend ? 8'd0 : cur.char_count;

  always_ff @(posedge clk) begin
    if (fifo_rd) begin
      cur <= fifo_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_pend <= 1'b0;
      term_pend <= 1'b0;
    end else if (fifo_rd) begin
      char_pend <= fifo_data.char_valid;
      term_pend <= fifo_data.term_valid;
    end else if (take) begin
      if (char_pend) begin
        char_pend <= 1'b0;
      end else begin
        term_pend <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/utf8_to_ucs2_stream_decoder_top.sv @@
// top level of the utf-8 to 16-bit code point stream decoder
// path: a byte's request goes into the queue, then into the back's result register
// throughput: one byte per cycle in while not full, one result per cycle out while
//   pop is held; a byte with a character and a terminator gives them one after the other
// reset: rst (synchronous) empties the queue, clears string state, cap returns to 128
module utf8_to_ucs2_stream_decoder_top import u8dec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration: byte cap per string
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // byte input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result output queue side
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_point,
  output logic [7:0]  char_index,
  output logic        is_unknown,
  output logic        is_terminator,
  output logic [7:0]  char_count
);

  u8dec_entry_t       front_entry;
  logic               front_push;
  u8dec_entry_t       fifo_data;
  logic               fifo_rd;
  u8dec_fifo_status_t fifo_status;
  logic               accept;

  // the queue fills when results are taken slower than requests arrive
  assign full   = fifo_status.full;
  assign accept = push && !fifo_status.full;

  // decode state lives in the front; each accepted byte inside the cap advances it
  u8dec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .entry_push  (front_push),
    .entry       (front_entry)
  );

  // holds requests so the front keeps going while results wait
  u8dec_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_push),
    .wr_data (front_entry),
    .rd_en   (fifo_rd),
    .rd_data (fifo_data),
    .status  (fifo_status)
  );

  // character result first, terminator second when a byte gives both
  u8dec_back u_back (
    .clk           (clk),
    .rst           (rst),
    .fifo_status   (fifo_status),
    .fifo_data     (fifo_data),
    .fifo_rd       (fifo_rd),
    .pop           (pop),
    .empty         (empty),
    .code_point    (code_point),
    .char_index    (char_index),
    .is_unknown    (is_unknown),
    .is_terminator (is_terminator),
    .char_count    (char_count)
  );

endmodule

@@ bench/tb.sv @@
// self-checking bench for the utf-8 to 16-bit code point stream decoder
module tb;
  import u8dec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one decoded request as it leaves the block
  typedef struct packed {
    logic [15:0] cp;
    logic [7:0]  idx;
    logic        unk;
    logic        term;
    logic [7:0]  cnt;
  } code_res_t;

  // a stimulus row is either a byte of a string or a new byte cap
  typedef enum logic [0:0] {
    RowByte,
    RowCap
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] val;
    logic       last;
    logic       pinned;  // row causes exactly the one request in want
    code_res_t  want;
  } stim_row_t;

  localparam code_res_t NoPin = '0;
  localparam int unsigned ItemTarget = 600;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned SettleCycles = 6;

  // directed part: extremes, each byte class, cut-short strings, cap of zero,
  // a sequence left open at the cap, and a final byte that gives both a character and a terminator
  localparam stim_row_t Script [25] = '{
    '{RowByte, 8'h00, 1'b0, 1'b1, '{16'h0000, 8'd0, 1'b0, 1'b0, 8'd0}},
    '{RowByte, 8'h7f, 1'b0, 1'b1, '{16'h007f, 8'd1, 1'b0, 1'b0, 8'd0}},
    '{RowByte, 8'h80, 1'b0, 1'b1, '{16'h0000, 8'd2, 1'b1, 1'b0, 8'd0}},
    '{RowByte, 8'hf0, 1'b0, 1'b1, '{16'h0000, 8'd3, 1'b1, 1'b0, 8'd0}},
    '{RowByte, 8'hff, 1'b0, 1'b1, '{16'h0000, 8'd4, 1'b1, 1'b0, 8'd0}},
    '{RowByte, 8'hc0, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'h80, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'hdf, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'hbf, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'he0, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'h80, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'h80, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'hef, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'hbf, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'hff, 1'b1, 1'b0, NoPin},
    '{RowByte, 8'he2, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'h82, 1'b1, 1'b1, '{16'h0000, 8'd0, 1'b0, 1'b1, 8'd0}},
    '{RowByte, 8'h41, 1'b0, 1'b1, '{16'h0041, 8'd0, 1'b0, 1'b0, 8'd0}},
    '{RowByte, 8'hc3, 1'b1, 1'b1, '{16'h0000, 8'd0, 1'b0, 1'b1, 8'd1}},
    '{RowCap,  8'd0,  1'b0, 1'b0, NoPin},
    '{RowByte, 8'h41, 1'b1, 1'b1, '{16'h0000, 8'd0, 1'b0, 1'b1, 8'd0}},
    '{RowCap,  8'd2,  1'b0, 1'b0, NoPin},
    '{RowByte, 8'h41, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'he2, 1'b0, 1'b0, NoPin},
    '{RowByte, 8'h41, 1'b1, 1'b1, '{16'h0000, 8'd0, 1'b0, 1'b1, 8'd1}}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] code_point;
  logic [7:0]  char_index;
  logic        is_unknown;
  logic        is_terminator;
  logic [7:0]  char_count;

  utf8_to_ucs2_stream_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .empty         (empty),
    .pop           (pop),
    .code_point    (code_point),
    .char_index    (char_index),
    .is_unknown    (is_unknown),
    .is_terminator (is_terminator),
    .char_count    (char_count)
  );

  // decoder shadow state, mirrors the block's per-string registers
  logic [7:0] byte_cap = MaxBytesReset;
  logic [7:0] lead = 8'd0;
  logic [7:0] first_cont = 8'd0;
  logic [1:0] need = NeedNone;
  logic [7:0] emitted = 8'd0;
  logic [7:0] seen = 8'd0;
  logic       halted = 1'b0;

  code_res_t awaited_codes[$];  // requests still to come out of the block, oldest first
  code_res_t byte_codes[$];     // requests caused by the byte just accepted
  logic [7:0] string_bytes[$];  // random string under construction

  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned random_taken = 0;
  int unsigned strings_sent = 0;
  int unsigned caps_written = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous fixed limit, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic void emit_char(input logic [15:0] cp, input logic unk);
    byte_codes.push_back('{cp, emitted, unk, 1'b0, 8'd0});
    emitted = emitted + 8'd1;
  endfunction

  // advance the shadow decoder by one byte
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    if (!halted && seen < byte_cap) begin
      seen = seen + 8'd1;
      if (need == NeedNone) begin
        if (!b[7]) begin
          emit_char({8'h00, b}, 1'b0);
        end else if (b[7:4] == HiThreeByte) begin
          lead = b;
          need = NeedTwo;
        end else if (b[7:4] == HiTwoByteA || b[7:4] == HiTwoByteB) begin
          lead = b;
          need = NeedOne;
        end else begin
          // stray continuation or four-byte lead
          emit_char(16'h0000, 1'b1);
        end
      end else if (need == NeedTwo) begin
        first_cont = b;
        need = NeedOne;
      end else begin
        // continuation bits are taken as they are, never checked
        need = NeedNone;
        if (lead[7:4] == HiThreeByte) begin
          emit_char({lead[3:0], first_cont[5:0], b[5:0]}, 1'b0);
        end else begin
          emit_char({5'b00000, lead[4:0], b[5:0]}, 1'b0);
        end
      end
      // a sequence still open at the cap can never finish
      if (need != NeedNone && seen >= byte_cap) begin
        halted = 1'b1;
        need = NeedNone;
      end
    end
    if (last) begin
      byte_codes.push_back('{16'h0000, 8'd0, 1'b0, 1'b1, emitted});
      lead = 8'd0;
      first_cont = 8'd0;
      need = NeedNone;
      emitted = 8'd0;
      seen = 8'd0;
      halted = 1'b0;
    end
  endfunction

  // one byte request: optional gap, then hold push until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic last, input logic pinned,
                           input code_res_t want);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    // accepted at this edge: predict what it causes
    byte_codes.delete();
    decode_byte(b, last);
    if (pinned) begin
      awaited_codes.push_back(want);
    end else begin
      foreach (byte_codes[i]) awaited_codes.push_back(byte_codes[i]);
    end
  endtask

  // stop feeding, wait for every outstanding request, then let the pipe settle
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (awaited_codes.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // the cap register is only written with the block idle
  task automatic set_cap(input logic [7:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    byte_cap = v;
    caps_written++;
  endtask

  function automatic logic [7:0] cont_byte();
    // mostly proper continuation bytes, sometimes anything
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // append one random character, well formed most of the time
  function automatic void add_char();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: begin
        string_bytes.push_back({1'b0, 7'($urandom)});
      end
      4, 5: begin
        string_bytes.push_back({3'b110, 5'($urandom)});
        string_bytes.push_back(cont_byte());
      end
      6, 7: begin
        string_bytes.push_back({4'b1110, 4'($urandom)});
        string_bytes.push_back(cont_byte());
        string_bytes.push_back(cont_byte());
      end
      8: begin
        // unknown lead: stray continuation or four-byte and up
        if ($urandom_range(0, 1) == 1) string_bytes.push_back({2'b10, 6'($urandom)});
        else string_bytes.push_back({4'b1111, 4'($urandom)});
      end
      default: begin
        string_bytes.push_back(8'($urandom));
      end
    endcase
  endfunction

  // build a string and push it; the end may cut the last character short
  task automatic send_string(input bit long_one);
    int unsigned len;
    if (long_one) len = int'(byte_cap) + $urandom_range(0, 5);
    else if (byte_cap == 8'd0) len = $urandom_range(1, 4);
    else len = $urandom_range(1, 24);
    if (len == 0) len = 1;
    string_bytes.delete();
    while (string_bytes.size() < len) add_char();
    while (string_bytes.size() > len) void'(string_bytes.pop_back());
    in_quiet = ($urandom_range(0, 5) == 0);
    foreach (string_bytes[i]) begin
      send_byte(string_bytes[i], i == len - 1, 1'b0, NoPin);
      random_taken++;
    end
    strings_sent++;
  endtask

  // result side: random stalls with quiet stretches, pop held until a request moves
  initial begin
    int unsigned stall;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 29) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // compare every request taken from the block with the oldest prediction
  always @(posedge clk) begin
    code_res_t got;
    code_res_t want;
    if (!rst && pop && !empty) begin
      got = {code_point, char_index, is_unknown, is_terminator, char_count};
      if (awaited_codes.size() == 0) begin
        if (errors < MaxReported)
          $display("unexpected request: cp=%h idx=%0d unk=%b term=%b cnt=%0d",
                   got.cp, got.idx, got.unk, got.term, got.cnt);
        errors++;
      end else begin
        want = awaited_codes.pop_front();
        checked++;
        if (got !== want) begin
          if (errors < MaxReported) begin
            $display("mismatch: want cp=%h idx=%0d unk=%b term=%b cnt=%0d",
                     want.cp, want.idx, want.unk, want.term, want.cnt);
            $display("          got  cp=%h idx=%0d unk=%b term=%b cnt=%0d",
                     got.cp, got.idx, got.unk, got.term, got.cnt);
          end
          errors++;
        end
      end
    end
  end

  // main sequence: reset, directed table, then random phases over several caps
  initial begin
    int unsigned phase;
    int unsigned phase_start;
    int unsigned phase_strings;
    logic [7:0] next_cap;
    // synchronous reset at the start, never again
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (Script[i]) begin
      if (Script[i].kind == RowCap) begin
        set_cap(Script[i].val);
      end else begin
        send_byte(Script[i].val, Script[i].last, Script[i].pinned, Script[i].want);
      end
    end

    // random phases: widest cap first (one string reaches or runs past it), then
    // a cap of one, the reset value, zero, and then alternating random caps
    phase = 0;
    while (random_taken < ItemTarget) begin
      case (phase)
        0: next_cap = 8'd255;
        1: next_cap = 8'd1;
        2: next_cap = MaxBytesReset;
        3: next_cap = 8'd0;
        default: next_cap = (phase % 2 == 1) ? 8'($urandom_range(2, 12))
                                             : 8'($urandom_range(1, 255));
      endcase
      set_cap(next_cap);
      phase_start = random_taken;
      phase_strings = 0;
      // tiny caps drop almost everything, so give them a fixed few strings
      while ((byte_cap <= 8'd1) ? (phase_strings < 5)
                                : (random_taken - phase_start < 100 &&
                                   random_taken < ItemTarget)) begin
        send_string((phase_strings == 0 && byte_cap == 8'd255) ||
                    (byte_cap > 8'd1 && $urandom_range(0, 11) == 0));
        phase_strings++;
      end
      phase++;
    end

    // all bytes are in: wait for every request, then watch for strays
    drain();
    repeat (12) @(posedge clk);
    errors += awaited_codes.size();

    $display("decoded %0d random strings (%0d bytes taken) over %0d cap writes",
             strings_sent, random_taken, caps_written);
    $display("checked %0d output requests, %0d errors", checked, errors);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/u8dec_pkg.sv
hw/rtl/u8dec_front.sv
hw/rtl/u8dec_fifo.sv
hw/rtl/u8dec_back.sv
hw/rtl/utf8_to_ucs2_stream_decoder_top.sv
bench/tb.sv
